// File: design/rtcpsr_pkg.sv
package rtcpsr_pkg;

    localparam logic [1:0]  RTCP_VERSION     = 2'd2;
    localparam logic [7:0]  RTCP_TYPE_SR     = 8'd200;
    localparam logic [7:0]  RTCP_TYPE_RR     = 8'd201;
    // SR of at least 28 bytes: (length + 1) * 4 >= 28
    localparam logic [15:0] SR_MIN_LEN_WORDS = 16'd6;
    localparam logic [22:0] LOSS_MAX         = 23'h7FFFFF;
    localparam logic [7:0]  RR_VPC           = 8'h80 | 8'h01;
    localparam logic [15:0] RR_LENGTH        = 16'h0007;
    localparam logic [31:0] RR_HEADER        = {RR_VPC, RTCP_TYPE_RR, RR_LENGTH};

    // receiver report word positions
    localparam logic [2:0] WORD_HEADER = 3'd0;
    localparam logic [2:0] WORD_OWN    = 3'd1;
    localparam logic [2:0] WORD_SOURCE = 3'd2;
    localparam logic [2:0] WORD_LOSS   = 3'd3;
    localparam logic [2:0] WORD_SEQ    = 3'd4;
    localparam logic [2:0] WORD_JITTER = 3'd5;
    localparam logic [2:0] WORD_LSR    = 3'd6;
    localparam logic [2:0] WORD_DLSR   = 3'd7;

    // APB register byte address bit 2 selects the register
    localparam logic REG_OWN_SSRC = 1'b0;

    typedef struct packed {
        logic        seen;
        logic [31:0] ssrc;
        logic [31:0] ntp_hi;
        logic [31:0] ntp_lo;
        logic [31:0] rtp;
    } sr_info_t;

endpackage

// File: design/rtcp_sender_report_parser_and_rr_builder_core.sv
// Channel   Handshake            Payload
// input     in_valid/in_ready    func, data_byte, end_of_datagram, report fields
// output    out_valid/out_ready  kind, report_word, report_last, sr_* fields
// config    APB write/read       own_ssrc at byte address 0
//
// Datagram bytes stream in back to back while results drain.
// A report request occupies the output register for eight words, one at a time,
// and the input is held off until the eighth word is taken.
// A captured SR is shown in the cycle after its last byte; the output register holds one
// result, so a stalled output stalls the input.
// rst_n clears the parser, the captured SR and own_ssrc.
module rtcp_sender_report_parser_and_rr_builder_core
    import rtcpsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  data_byte,
    input  logic        end_of_datagram,
    input  logic [31:0] source_ssrc,
    input  logic [15:0] highest_sequence,
    input  logic [31:0] lost_total,
    input  logic [31:0] arrival_jitter,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [31:0] report_word,
    output logic        report_last,
    output logic [31:0] sr_ssrc,
    output logic [31:0] sr_ntp_seconds,
    output logic [31:0] sr_ntp_fraction,
    output logic [31:0] sr_rtp_time
);

    logic [31:0] own_ssrc_reg;
    logic        out_valid_reg;
    logic        rpt_reg;
    logic [2:0]  cnt_reg;
    logic [31:0] src_reg;
    logic [15:0] seq_reg;
    logic [22:0] lost_reg;
    logic [31:0] jit_reg;
    logic [31:0] word_mux;
    logic [31:0] lsr;
    logic        accept;
    logic        out_take;
    logic        sr_commit;
    sr_info_t    sr_info;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OWN_SSRC) ? own_ssrc_reg : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_ssrc_reg <= '0;
        else if (psel && penable && pwrite && (paddr[2] == REG_OWN_SSRC))
            own_ssrc_reg <= pwdata;
    end

    // handshake
    assign in_ready = !out_valid_reg
                      || (out_ready && (!rpt_reg || (cnt_reg == WORD_DLSR)));
    assign accept   = in_valid && in_ready;
    assign out_take = out_valid_reg && out_ready;

    rtcpsr_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_en         (accept && !func),
        .data_byte       (data_byte),
        .end_of_datagram (end_of_datagram),
        .sr_commit       (sr_commit),
        .sr_info         (sr_info)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rpt_reg       <= 1'b0;
            cnt_reg       <= WORD_HEADER;
        end
        else if (accept && func)
        begin
            out_valid_reg <= 1'b1;
            rpt_reg       <= 1'b1;
            cnt_reg       <= WORD_HEADER;
        end
        else if (sr_commit)
        begin
            out_valid_reg <= 1'b1;
            rpt_reg       <= 1'b0;
        end
        else if (out_take)
        begin
            // advance through the report words; release after the last one, or once an SR result is taken
            if (rpt_reg && (cnt_reg != WORD_DLSR))
                cnt_reg <= cnt_reg + 3'd1;
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && func)
        begin
            src_reg  <= source_ssrc;
            seq_reg  <= highest_sequence;
            lost_reg <= (lost_total > {9'h0, LOSS_MAX}) ? LOSS_MAX : lost_total[22:0];
            jit_reg  <= arrival_jitter;
        end
    end

    assign lsr = sr_info.seen ? {sr_info.ntp_hi[15:0], sr_info.ntp_lo[31:16]} : 32'h0;

    always_comb
    begin
        case (cnt_reg)
            WORD_HEADER: word_mux = RR_HEADER;
            WORD_OWN:    word_mux = own_ssrc_reg;
            WORD_SOURCE: word_mux = src_reg;
            WORD_LOSS:   word_mux = {9'h0, lost_reg};
            WORD_SEQ:    word_mux = {16'h0, seq_reg};
            WORD_JITTER: word_mux = jit_reg;
            WORD_LSR:    word_mux = lsr;
            WORD_DLSR:   word_mux = 32'h0;
            default:     word_mux = 32'h0;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign kind            = !rpt_reg;
    assign report_word     = rpt_reg ? word_mux : 32'h0;
    assign report_last     = rpt_reg && (cnt_reg == WORD_DLSR);
    assign sr_ssrc         = rpt_reg ? 32'h0 : sr_info.ssrc;
    assign sr_ntp_seconds  = rpt_reg ? 32'h0 : sr_info.ntp_hi;
    assign sr_ntp_fraction = rpt_reg ? 32'h0 : sr_info.ntp_lo;
    assign sr_rtp_time     = rpt_reg ? 32'h0 : sr_info.rtp;

    a_hold_during_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rpt_reg && (cnt_reg != WORD_DLSR)) |-> !in_ready)
        else $error("input taken while report words remain");

    a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func) |=> (out_valid && !kind && (report_word == RR_HEADER)))
        else $error("report request did not start with the header word");

    a_sr_shown: assert property (@(posedge clk) disable iff (!rst_n)
        sr_commit |=> (out_valid && kind && sr_info.seen))
        else $error("committed sender report not presented");

    a_last_is_report: assert property (@(posedge clk) disable iff (!rst_n)
        report_last |-> (!kind && (report_word == 32'h0)))
        else $error("last flag on a non-report result");

endmodule

// File: design/rtcpsr_parser.sv
module rtcpsr_parser
    import rtcpsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,
    input  logic [7:0] data_byte,
    input  logic       end_of_datagram,
    output logic       sr_commit,
    output sr_info_t   sr_info
);

    logic [17:0]      off_reg, off_next;
    logic [15:0]      len_reg, len_next, len_cur;
    logic [7:0]       ptype_reg, ptype_next, ptype_cur;
    logic             drop_reg, drop_next, drop_cur;
    logic [3:0][31:0] pend_reg, pend_next;
    sr_info_t         saved_reg, saved_next;
    logic [1:0]       pend_idx;
    logic             pkt_end;

    assign pend_idx = 2'(off_reg[4:2] - 3'd1);

    always_comb
    begin
        len_cur   = len_reg;
        ptype_cur = ptype_reg;
        drop_cur  = drop_reg;
        pend_next = pend_reg;
        if (!drop_reg)
        begin
            if (off_reg == 18'd0)
            begin
                if (data_byte[7:6] != RTCP_VERSION)
                    drop_cur = 1'b1;
            end
            else if (off_reg == 18'd1)
                ptype_cur = data_byte;
            else if (off_reg == 18'd2)
                len_cur = {data_byte, 8'h00};
            else if (off_reg == 18'd3)
                len_cur = {len_reg[15:8], data_byte};
            else if (off_reg < 18'd20)
                pend_next[pend_idx] = {pend_reg[pend_idx][23:0], data_byte};
        end

        // last byte of subpacket sits at ((length + 1) * 4) - 1
        pkt_end   = !drop_cur && (off_reg >= 18'd3) && (off_reg == {len_cur, 2'b11});
        sr_commit = byte_en && pkt_end && (ptype_cur == RTCP_TYPE_SR)
                    && (len_cur >= SR_MIN_LEN_WORDS);

        off_next   = off_reg;
        len_next   = len_reg;
        ptype_next = ptype_reg;
        drop_next  = drop_reg;
        saved_next = saved_reg;
        if (byte_en)
        begin
            if (!drop_reg)
            begin
                drop_next  = drop_cur;
                len_next   = len_cur;
                ptype_next = ptype_cur;
                if (!drop_cur)
                begin
                    if (pkt_end)
                    begin
                        off_next   = '0;
                        len_next   = '0;
                        ptype_next = '0;
                    end
                    else
                        off_next = off_reg + 18'd1;
                end
            end
            if (sr_commit)
            begin
                saved_next.seen   = 1'b1;
                saved_next.ssrc   = pend_next[0];
                saved_next.ntp_hi = pend_next[1];
                saved_next.ntp_lo = pend_next[2];
                saved_next.rtp    = pend_next[3];
            end
            // start over for the next datagram
            if (end_of_datagram)
            begin
                off_next   = '0;
                len_next   = '0;
                ptype_next = '0;
                drop_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            len_reg   <= '0;
            ptype_reg <= '0;
            drop_reg  <= 1'b0;
            pend_reg  <= '0;
            saved_reg <= '0;
        end
        else
        begin
            off_reg   <= off_next;
            len_reg   <= len_next;
            ptype_reg <= ptype_next;
            drop_reg  <= drop_next;
            if (byte_en && !drop_reg)
                pend_reg <= pend_next;
            saved_reg <= saved_next;
        end
    end

    assign sr_info = saved_reg;

endmodule
